// ===== rtl/imufad_pkg.sv =====
// Shared types, register codes, thresholds and phase codes of the IMU fall and activity detector.
`default_nettype none

package imufad_pkg;

  // Payload field widths
  localparam int SAMPLE_W   = 16;
  localparam int TIME_W     = 32;

  // Configuration port and register widths
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int ACC_W      = 15;
  localparam int MS_W       = 16;
  localparam int CNT_W      = 4;
  localparam int SQ_CFG_W   = 2 * ACC_W;

  // Depth of the queue between classifier and sequencer
  localparam int QUEUE_DEPTH_DEF = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_ACCEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMPACT_ACCEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POST_ACCEL      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GYRO_SUPPORT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FREEFALL_WIN_MS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_POST_IMPACT_MS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_MS        = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_SAMPLES = 3'd7;

  // Register reset values
  localparam logic [ACC_W-1:0] RST_FREEFALL_ACCEL  = 15'd768;
  localparam logic [ACC_W-1:0] RST_IMPACT_ACCEL    = 15'd4608;
  localparam logic [ACC_W-1:0] RST_POST_ACCEL      = 15'd3328;
  localparam logic [ACC_W-1:0] RST_GYRO_SUPPORT    = 15'd4096;
  localparam logic [MS_W-1:0]  RST_FREEFALL_WIN_MS = 16'd1500;
  localparam logic [MS_W-1:0]  RST_POST_IMPACT_MS  = 16'd1000;
  localparam logic [MS_W-1:0]  RST_ALERT_MS        = 16'd3000;
  localparam logic [CNT_W-1:0] RST_CONFIRM_SAMPLES = 4'd3;

  // Fixed motion thresholds, squared
  localparam logic [31:0] ACC_REST_ENTER_SQ = 32'(2944 * 2944);
  localparam logic [31:0] ACC_REST_EXIT_SQ  = 32'(3200 * 3200);
  localparam logic [31:0] ACC_HIGH_ENTER_SQ = 32'(4864 * 4864);
  localparam logic [31:0] ACC_HIGH_EXIT_SQ  = 32'(4352 * 4352);
  localparam logic [31:0] GYR_MOVE_ENTER_SQ = 32'(1126 * 1126);
  localparam logic [31:0] GYR_REST_SQ       = 32'(717 * 717);
  localparam logic [31:0] GYR_HIGH_ENTER_SQ = 32'(5120 * 5120);
  localparam logic [31:0] GYR_HIGH_EXIT_SQ  = 32'(4096 * 4096);

  // Motion classes
  localparam logic [1:0] CLS_REST = 2'd0;
  localparam logic [1:0] CLS_MOVE = 2'd1;
  localparam logic [1:0] CLS_HIGH = 2'd2;
  localparam logic [1:0] CLS_FALL = 2'd3;

  // Fall phases
  localparam logic [2:0] PH_NORMAL    = 3'd0;
  localparam logic [2:0] PH_FREE      = 3'd1;
  localparam logic [2:0] PH_IMPACT    = 3'd2;
  localparam logic [2:0] PH_CHECK     = 3'd3;
  localparam logic [2:0] PH_CONFIRMED = 3'd4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] accel_x;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_x;
    logic signed [SAMPLE_W-1:0] gyro_y;
    logic signed [SAMPLE_W-1:0] gyro_z;
    logic [TIME_W-1:0]          time_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0] motion_class;
    logic [2:0] fall_phase;
  } out_item_t;

  // Register file contents plus squared thresholds
  typedef struct packed {
    logic [ACC_W-1:0]    freefall_accel;
    logic [ACC_W-1:0]    impact_accel;
    logic [ACC_W-1:0]    post_impact_accel;
    logic [ACC_W-1:0]    impact_gyro_support;
    logic [MS_W-1:0]     freefall_window_ms;
    logic [MS_W-1:0]     post_impact_ms;
    logic [MS_W-1:0]     alert_ms;
    logic [CNT_W-1:0]    confirm_samples;
    logic [SQ_CFG_W-1:0] freefall_sq;
    logic [SQ_CFG_W-1:0] impact_sq;
    logic [SQ_CFG_W-1:0] post_sq;
    logic [SQ_CFG_W-1:0] support_sq;
  } cfg_t;

  // Classified sample handed from front to back
  typedef struct packed {
    logic        ff_lt;
    logic        imp_ge;
    logic        post_ge;
    logic        g_move;
    logic        high;
    logic        moving;
    logic        resting;
    logic        stay_high;
    logic [31:0] g_sat;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/imufad_cfg.sv =====
// Configuration registers and their registered squares.
`default_nettype none

module imufad_cfg (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [imufad_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [imufad_pkg::CFG_DATA_W-1:0] cfg_data,
  output imufad_pkg::cfg_t                       cfg
);
  import imufad_pkg::*;

  logic [ACC_W-1:0]    ff_acc_r, imp_acc_r, post_acc_r, sup_r;
  logic [MS_W-1:0]     ff_win_r, post_ms_r, alert_r;
  logic [CNT_W-1:0]    confirm_r;
  logic [SQ_CFG_W-1:0] ff_sq_r, imp_sq_r, post_sq_r, sup_sq_r;

  // Write the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_acc_r   <= RST_FREEFALL_ACCEL;
      imp_acc_r  <= RST_IMPACT_ACCEL;
      post_acc_r <= RST_POST_ACCEL;
      sup_r      <= RST_GYRO_SUPPORT;
      ff_win_r   <= RST_FREEFALL_WIN_MS;
      post_ms_r  <= RST_POST_IMPACT_MS;
      alert_r    <= RST_ALERT_MS;
      confirm_r  <= RST_CONFIRM_SAMPLES;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FREEFALL_ACCEL:  ff_acc_r   <= cfg_data[ACC_W-1:0];
        REG_IMPACT_ACCEL:    imp_acc_r  <= cfg_data[ACC_W-1:0];
        REG_POST_ACCEL:      post_acc_r <= cfg_data[ACC_W-1:0];
        REG_GYRO_SUPPORT:    sup_r      <= cfg_data[ACC_W-1:0];
        REG_FREEFALL_WIN_MS: ff_win_r   <= cfg_data[MS_W-1:0];
        REG_POST_IMPACT_MS:  post_ms_r  <= cfg_data[MS_W-1:0];
        REG_ALERT_MS:        alert_r    <= cfg_data[MS_W-1:0];
        REG_CONFIRM_SAMPLES: confirm_r  <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Square the magnitude thresholds, registered in the cycle after the registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ff_sq_r   <= SQ_CFG_W'(RST_FREEFALL_ACCEL) * SQ_CFG_W'(RST_FREEFALL_ACCEL);
      imp_sq_r  <= SQ_CFG_W'(RST_IMPACT_ACCEL) * SQ_CFG_W'(RST_IMPACT_ACCEL);
      post_sq_r <= SQ_CFG_W'(RST_POST_ACCEL) * SQ_CFG_W'(RST_POST_ACCEL);
      sup_sq_r  <= SQ_CFG_W'(RST_GYRO_SUPPORT) * SQ_CFG_W'(RST_GYRO_SUPPORT);
    end else begin
      ff_sq_r   <= SQ_CFG_W'(ff_acc_r) * SQ_CFG_W'(ff_acc_r);
      imp_sq_r  <= SQ_CFG_W'(imp_acc_r) * SQ_CFG_W'(imp_acc_r);
      post_sq_r <= SQ_CFG_W'(post_acc_r) * SQ_CFG_W'(post_acc_r);
      sup_sq_r  <= SQ_CFG_W'(sup_r) * SQ_CFG_W'(sup_r);
    end
  end

  always_comb begin
    cfg.freefall_accel      = ff_acc_r;
    cfg.impact_accel        = imp_acc_r;
    cfg.post_impact_accel   = post_acc_r;
    cfg.impact_gyro_support = sup_r;
    cfg.freefall_window_ms  = ff_win_r;
    cfg.post_impact_ms      = post_ms_r;
    cfg.alert_ms            = alert_r;
    cfg.confirm_samples     = confirm_r;
    cfg.freefall_sq         = ff_sq_r;
    cfg.impact_sq           = imp_sq_r;
    cfg.post_sq             = post_sq_r;
    cfg.support_sq          = sup_sq_r;
  end

endmodule

`default_nettype wire

// ===== rtl/imufad_front.sv =====
// Front end: squares the sample axes, sums them and classifies against thresholds.
`default_nettype none

module imufad_front #(
  parameter int QW = $bits(imufad_pkg::flags_t) + imufad_pkg::TIME_W
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire imufad_pkg::in_item_t in_data,
  input  wire imufad_pkg::cfg_t     cfg,
  output logic                      push,
  output logic [QW-1:0]             push_data,
  input  wire logic                 full
);
  import imufad_pkg::*;

  localparam int S  = SAMPLE_W;
  localparam int GW = 2 * S + 1;
  localparam int CW = (GW > SQ_CFG_W) ? GW : SQ_CFG_W;
  localparam int XW = GW + 32;

  logic [S-1:0]     raw [6];
  logic [S-1:0]     mag [6];
  logic [2*S-1:0]   sq_r [6];
  logic [TIME_W-1:0] time_r;
  logic             s1_v_r, s1_v_nxt;
  logic             in_acc;
  logic [GW-1:0]    a_sum, g_sum;
  logic [CW-1:0]    a_c, g_c;
  logic [XW-1:0]    g_x;
  flags_t           flags;

  // Take the magnitude of each axis
  always_comb begin
    raw[0] = S'($unsigned(in_data.accel_x));
    raw[1] = S'($unsigned(in_data.accel_y));
    raw[2] = S'($unsigned(in_data.accel_z));
    raw[3] = S'($unsigned(in_data.gyro_x));
    raw[4] = S'($unsigned(in_data.gyro_y));
    raw[5] = S'($unsigned(in_data.gyro_z));
    for (int i = 0; i < 6; i++) begin
      mag[i] = raw[i][S-1] ? (~raw[i] + S'(1)) : raw[i];
    end
  end

  // Hold the squares stage until the queue has room
  assign in_stall = s1_v_r && full;
  assign in_acc   = in_valid && !in_stall;
  assign push     = s1_v_r && !full;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (in_acc) begin
      s1_v_nxt = 1'b1;
    end else if (push) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
    end
  end

  // Square each axis
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < 6; i++) begin
        sq_r[i] <= (2*S)'(mag[i]) * (2*S)'(mag[i]);
      end
      time_r <= in_data.time_ms;
    end
  end

  // Sum the squares and compare with the squared thresholds
  always_comb begin
    a_sum = GW'(sq_r[0]) + GW'(sq_r[1]) + GW'(sq_r[2]);
    g_sum = GW'(sq_r[3]) + GW'(sq_r[4]) + GW'(sq_r[5]);
    a_c   = CW'(a_sum);
    g_c   = CW'(g_sum);
    g_x   = XW'(g_sum);

    flags.ff_lt     = a_c <  CW'(cfg.freefall_sq);
    flags.imp_ge    = a_c >= CW'(cfg.impact_sq);
    flags.post_ge   = a_c >= CW'(cfg.post_sq);
    flags.g_move    = g_c >= CW'(GYR_MOVE_ENTER_SQ);
    flags.high      = (a_c >= CW'(ACC_HIGH_ENTER_SQ)) || (g_c >= CW'(GYR_HIGH_ENTER_SQ));
    flags.moving    = (a_c >= CW'(ACC_REST_EXIT_SQ)) || (g_c >= CW'(GYR_MOVE_ENTER_SQ));
    flags.resting   = (a_c <= CW'(ACC_REST_ENTER_SQ)) && (g_c <= CW'(GYR_REST_SQ));
    flags.stay_high = (a_c >= CW'(ACC_HIGH_EXIT_SQ)) || (g_c >= CW'(GYR_HIGH_EXIT_SQ));
    flags.g_sat     = (g_x[XW-1:32] != '0) ? 32'hFFFF_FFFF : g_x[31:0];
  end

  assign push_data = QW'({flags, time_r});

endmodule

`default_nettype wire

// ===== rtl/imufad_queue.sv =====
// Short queue of classified samples between front end and sequencer.
`default_nettype none

module imufad_queue #(
  parameter int W     = $bits(imufad_pkg::flags_t) + imufad_pkg::TIME_W,
  parameter int DEPTH = imufad_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              nonempty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [NW-1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == NW'(DEPTH));
  assign nonempty = (cnt_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  // Store a request
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + NW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - NW'(1);
    end
  end

  // Advance the pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/imufad_back.sv =====
// Back end: fall sequencer, hysteretic motion classifier and output register.
`default_nettype none

module imufad_back #(
  parameter int QW = $bits(imufad_pkg::flags_t) + imufad_pkg::TIME_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire imufad_pkg::cfg_t      cfg,
  input  wire logic                  q_valid,
  input  wire logic [QW-1:0]         q_data,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output imufad_pkg::out_item_t      out_data
);
  import imufad_pkg::*;

  localparam int T = TIME_W;

  flags_t         fl;
  logic [T-1:0]   now, dt;
  logic [1:0]     cur_class_r, cur_class_nxt;
  logic [1:0]     pend_class_r, pend_class_nxt;
  logic [CNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [2:0]     fall_step_r, fall_step_nxt;
  logic [T-1:0]   phase_start_r, phase_start_nxt;
  logic [31:0]    gyro_sq_r, gyro_sq_nxt;
  logic [1:0]     cand;
  logic           support, still;
  logic           out_valid_r;
  out_item_t      out_data_r;

  assign fl  = q_data[QW-1:T];
  assign now = q_data[T-1:0];
  assign dt  = now - phase_start_r;

  // Take a request when the output register is free or drains now
  assign pop = q_valid && (!out_valid_r || !out_stall);

  // Fall sequencer
  always_comb begin
    fall_step_nxt   = fall_step_r;
    phase_start_nxt = phase_start_r;
    gyro_sq_nxt     = gyro_sq_r;
    support         = {2'b00, gyro_sq_r} >= 34'(cfg.support_sq);
    still           = fl.post_ge || fl.g_move;
    case (fall_step_r)
      PH_NORMAL: begin
        if (fl.ff_lt) begin
          fall_step_nxt   = PH_FREE;
          phase_start_nxt = now;
        end
      end
      PH_FREE: begin
        if (dt > T'(cfg.freefall_window_ms)) begin
          fall_step_nxt = PH_NORMAL;
        end else if (fl.imp_ge) begin
          gyro_sq_nxt     = fl.g_sat;
          fall_step_nxt   = PH_IMPACT;
          phase_start_nxt = now;
        end else if (!fl.ff_lt) begin
          fall_step_nxt = PH_NORMAL;
        end
      end
      PH_IMPACT: begin
        fall_step_nxt   = PH_CHECK;
        phase_start_nxt = now;
      end
      PH_CHECK: begin
        if (dt >= T'(cfg.post_impact_ms)) begin
          if (support || still) begin
            fall_step_nxt   = PH_CONFIRMED;
            phase_start_nxt = now;
          end else begin
            fall_step_nxt = PH_NORMAL;
          end
        end
      end
      PH_CONFIRMED: begin
        if (dt >= T'(cfg.alert_ms)) begin
          fall_step_nxt = PH_NORMAL;
        end
      end
      default: fall_step_nxt = PH_NORMAL;
    endcase
  end

  // Candidate class with hysteresis on the current class
  always_comb begin
    if (cur_class_r == CLS_HIGH && fl.stay_high) begin
      cand = CLS_HIGH;
    end else if (cur_class_r != CLS_HIGH && fl.high) begin
      cand = CLS_HIGH;
    end else if (cur_class_r == CLS_MOVE && fl.resting) begin
      cand = CLS_REST;
    end else if (cur_class_r == CLS_MOVE || fl.moving) begin
      cand = CLS_MOVE;
    end else begin
      cand = CLS_REST;
    end
  end

  // Confirm a class change over consecutive samples; a confirmed fall sets CLS_FALL
  always_comb begin
    cur_class_nxt  = cur_class_r;
    pend_class_nxt = pend_class_r;
    pend_cnt_nxt   = pend_cnt_r;
    if (fall_step_nxt == PH_CONFIRMED) begin
      pend_cnt_nxt  = '0;
      cur_class_nxt = CLS_FALL;
    end else if (cand == cur_class_r) begin
      pend_cnt_nxt = '0;
    end else begin
      if (cand != pend_class_r) begin
        pend_class_nxt = cand;
        pend_cnt_nxt   = CNT_W'(1);
      end else if (pend_cnt_r < cfg.confirm_samples) begin
        pend_cnt_nxt = pend_cnt_r + CNT_W'(1);
      end
      if (pend_cnt_nxt >= cfg.confirm_samples) begin
        cur_class_nxt = cand;
        pend_cnt_nxt  = '0;
      end
    end
  end

  // Update state on each request taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_class_r   <= CLS_REST;
      pend_class_r  <= CLS_REST;
      pend_cnt_r    <= '0;
      fall_step_r   <= PH_NORMAL;
      phase_start_r <= '0;
      gyro_sq_r     <= '0;
    end else if (pop) begin
      cur_class_r   <= cur_class_nxt;
      pend_class_r  <= pend_class_nxt;
      pend_cnt_r    <= pend_cnt_nxt;
      fall_step_r   <= fall_step_nxt;
      phase_start_r <= phase_start_nxt;
      gyro_sq_r     <= gyro_sq_nxt;
    end
  end

  // Output register: load on pop, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r.motion_class <= cur_class_nxt;
      out_data_r.fall_phase   <= fall_step_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef NO_ASSERTIONS
  a_confirmed_class: assert property (@(posedge clk) disable iff (!rst_n)
    fall_step_r == PH_CONFIRMED |-> cur_class_r == CLS_FALL)
    else $error("confirmed fall without fall class");

  a_confirmed_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (fall_step_r == PH_CONFIRMED && pop) |=>
      (fall_step_r == PH_CONFIRMED || fall_step_r == PH_NORMAL))
    else $error("confirmed fall left to a phase other than normal");

  a_impact_once: assert property (@(posedge clk) disable iff (!rst_n)
    (fall_step_r == PH_IMPACT && pop) |=> fall_step_r == PH_CHECK)
    else $error("impact phase lasted more than one sample");
`endif

endmodule

`default_nettype wire

// ===== rtl/imu_fall_and_activity_detector.sv =====
// Top level of the IMU fall and activity detector.
`default_nettype none

// Accepts one IMU sample per clock cycle while in_stall is low and returns one result
// per sample, in order. A sample passes a squaring stage, is summed and compared against
// squared thresholds as it enters a short queue, and the sequencer stage then updates
// the fall phase and the motion class and loads the output register. The queue lets
// the front keep taking samples while a result waits in the output register; with
// the result side stalled, three samples are held (squaring stage plus two queue
// entries) before in_stall rises. Configuration is read as a sample is compared
// (thresholds, as registered squares) and sequenced, not when it is accepted.
module imu_fall_and_activity_detector #(
  parameter int QUEUE_DEPTH = imufad_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire imufad_pkg::in_item_t              in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output imufad_pkg::out_item_t                  out_data,
  input  wire logic                              cfg_we,
  input  wire logic [imufad_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [imufad_pkg::CFG_DATA_W-1:0] cfg_data
);
  import imufad_pkg::*;

  localparam int QW = $bits(flags_t) + TIME_W;

  cfg_t          cfg;
  logic          push, full, pop, nonempty;
  logic [QW-1:0] push_data, pop_data;

  imufad_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  imufad_front #(
    .QW          (QW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg       (cfg),
    .push      (push),
    .push_data (push_data),
    .full      (full)
  );

  imufad_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .nonempty  (nonempty)
  );

  imufad_back #(
    .QW        (QW)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (nonempty),
    .q_data    (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
